>>> sv/ipv4_rx_header_filter_defines.svh
// Assertion helpers for the IPv4 receive header filter.
`ifndef IPV4_RX_HEADER_FILTER_DEFINES_SVH
`define IPV4_RX_HEADER_FILTER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define IPV4F_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ipv4 filter: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted (active low).
`define IPV4F_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ipv4 filter: next-cycle check failed");

`endif

>>> sv/ipv4f_pkg.sv
`timescale 1ns / 1ps

package ipv4f_pkg;

    localparam int CFG_DATA_W  = 32;
    localparam int CFG_INDEX_W = 2;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_LOCAL_ADDRESS = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_UDP_ENABLED   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_TCP_ENABLED   = 2'd2;

    // Verdict codes
    localparam logic [2:0] VERDICT_ICMP      = 3'd0;
    localparam logic [2:0] VERDICT_UDP       = 3'd1;
    localparam logic [2:0] VERDICT_TCP       = 3'd2;
    localparam logic [2:0] VERDICT_BAD_CSUM  = 3'd3;
    localparam logic [2:0] VERDICT_WRONG_DST = 3'd4;
    localparam logic [2:0] VERDICT_FRAGMENT  = 3'd5;
    localparam logic [2:0] VERDICT_UNKNOWN   = 3'd6;
    localparam logic [2:0] VERDICT_MALFORMED = 3'd7;

    // Protocol numbers
    localparam logic [7:0] PROTO_ICMP = 8'd1;
    localparam logic [7:0] PROTO_TCP  = 8'd6;
    localparam logic [7:0] PROTO_UDP  = 8'd17;

    localparam logic [3:0]  IHL_MASK_MIN  = 4'd5;      // smallest legal IHL
    localparam logic [5:0]  HDR_LEN_MIN   = 6'd20;
    localparam logic [15:0] CSUM_GOOD     = 16'hffff;
    localparam logic [15:0] FLAG_MF       = 16'h2000;
    localparam logic [15:0] FRAG_OFS_MASK = 16'h1fff;

    typedef struct packed {
        logic [7:0] header_byte;
        logic       first_byte;
    } t_in_item;

    typedef struct packed {
        logic [2:0] verdict;
        logic [7:0] protocol_number;
        logic [5:0] header_length;
    } t_out_item;

    typedef struct packed {
        logic [31:0] local_address;
        logic        udp_enabled;
        logic        tcp_enabled;
    } t_cfg;

endpackage

>>> sv/ipv4f_cfg_regs.sv
`timescale 1ns / 1ps

module ipv4f_cfg_regs import ipv4f_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    output t_cfg                   o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_LOCAL_ADDRESS: r_cfg.local_address <= i_cfg_data;
                CFG_UDP_ENABLED:   r_cfg.udp_enabled   <= i_cfg_data[0];
                CFG_TCP_ENABLED:   r_cfg.tcp_enabled   <= i_cfg_data[0];
                default: ;  // unused index, write dropped
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> sv/ipv4f_parser.sv
`timescale 1ns / 1ps

module ipv4f_parser import ipv4f_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_step,
    input  t_in_item  i_item,
    output logic      o_result_valid,
    output t_out_item o_result
);

    logic        r_active;
    logic [5:0]  r_pos;
    logic [3:0]  r_words;
    logic [15:0] r_sum;
    logic [7:0]  r_pend;
    logic [31:0] r_dst;
    logic [15:0] r_frag;
    logic [7:0]  r_proto;

    logic        n_active;
    logic [5:0]  n_pos;
    logic [3:0]  n_words;
    logic [15:0] n_sum;
    logic [7:0]  n_pend;
    logic [31:0] n_dst;
    logic [15:0] n_frag;
    logic [7:0]  n_proto;

    // header fields as seen by this byte (cleared on a first byte)
    logic [5:0]  c_pos;
    logic [15:0] c_sum;
    logic [7:0]  c_pend;
    logic [31:0] c_dst;
    logic [15:0] c_frag;
    logic [7:0]  c_proto;

    logic [3:0]  ihl;
    logic [16:0] sum_raw;
    logic [15:0] sum_fold;
    logic [5:0]  total;
    logic        last;
    logic [2:0]  verdict;

    assign ihl   = i_item.header_byte[3:0];
    assign c_pos   = i_item.first_byte ? '0 : r_pos;
    assign c_sum   = i_item.first_byte ? '0 : r_sum;
    assign c_pend  = i_item.first_byte ? '0 : r_pend;
    assign c_dst   = i_item.first_byte ? '0 : r_dst;
    assign c_frag  = i_item.first_byte ? '0 : r_frag;
    assign c_proto = i_item.first_byte ? '0 : r_proto;
    assign n_words = i_item.first_byte ? ihl : r_words;

    // end-around carry; a second carry cannot occur
    assign sum_raw  = {1'b0, c_sum} + {1'b0, c_pend, i_item.header_byte};
    assign sum_fold = sum_raw[15:0] + {15'd0, sum_raw[16]};

    assign total = {n_words, 2'b00};
    assign last  = ({1'b0, c_pos} + 7'd1) >= {1'b0, total};

    always_comb begin
        n_sum   = c_pos[0] ? sum_fold : c_sum;
        n_pend  = c_pos[0] ? c_pend : i_item.header_byte;
        n_frag  = c_frag;
        n_proto = c_proto;
        n_dst   = c_dst;
        if (c_pos == 6'd6) begin
            n_frag = {i_item.header_byte, c_frag[7:0]};
        end else if (c_pos == 6'd7) begin
            n_frag = {c_frag[15:8], i_item.header_byte};
        end else if (c_pos == 6'd9) begin
            n_proto = i_item.header_byte;
        end else if (c_pos[5:2] == 4'b0100) begin
            n_dst = {c_dst[23:0], i_item.header_byte};
        end
    end

    always_comb begin
        priority if (n_sum != CSUM_GOOD) begin
            verdict = VERDICT_BAD_CSUM;
        end else if (n_dst != i_cfg.local_address) begin
            verdict = VERDICT_WRONG_DST;
        end else if ((n_frag & (FLAG_MF | FRAG_OFS_MASK)) != '0) begin
            verdict = VERDICT_FRAGMENT;
        end else if (n_proto == PROTO_ICMP) begin
            verdict = VERDICT_ICMP;
        end else if (n_proto == PROTO_UDP && i_cfg.udp_enabled) begin
            verdict = VERDICT_UDP;
        end else if (n_proto == PROTO_TCP && i_cfg.tcp_enabled) begin
            verdict = VERDICT_TCP;
        end else begin
            verdict = VERDICT_UNKNOWN;
        end
    end

    always_comb begin
        n_active       = r_active;
        n_pos          = r_pos;
        o_result_valid = 1'b0;
        o_result       = '{verdict: verdict, protocol_number: n_proto, header_length: total};
        if (i_item.first_byte && ihl < IHL_MASK_MIN) begin
            n_active       = 1'b0;
            o_result_valid = 1'b1;
            o_result       = '{verdict: VERDICT_MALFORMED, protocol_number: 8'd0,
                               header_length: total};
        end else if (i_item.first_byte || r_active) begin
            if (last) begin
                n_active       = 1'b0;
                n_pos          = '0;
                o_result_valid = 1'b1;
            end else begin
                n_active = 1'b1;
                n_pos    = c_pos + 6'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else if (i_step) begin
            r_active <= n_active;
        end
    end

    // header payload state, only read while a header is active
    always_ff @(posedge i_clk) begin
        if (i_step && (i_item.first_byte || r_active)) begin
            r_pos   <= n_pos;
            r_words <= n_words;
            r_sum   <= n_sum;
            r_pend  <= n_pend;
            r_dst   <= n_dst;
            r_frag  <= n_frag;
            r_proto <= n_proto;
        end
    end

endmodule

>>> sv/ipv4_rx_header_filter.sv
`timescale 1ns / 1ps
// Channel   Dir  Handshake                  Payload
// in        in   i_in_valid / o_in_ready    i_in_item   (header_byte, first_byte)
// out       out  o_out_valid / i_out_ready  o_out_item  (verdict, protocol_number,
//                                                        header_length)
// cfg       in   i_cfg_wr_en                i_cfg_index, i_cfg_data
//
// One header byte per cycle is accepted while the output is not stalled. A byte
// waits in the input register, and its verdict, if any, lands in the output
// register when the byte steps into the parser.
// The parser state (running sum, captured fields) advances once per byte.
// Synchronous active-low reset clears control state and the config registers.
// A stalled output holds the input register; input keeps flowing while the
// output register is free or being drained.
`include "ipv4_rx_header_filter_defines.svh"

module ipv4_rx_header_filter import ipv4f_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // input byte stream
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  t_in_item               i_in_item,
    // verdict stream
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output t_out_item              o_out_item,
    // configuration writes
    input  logic                   i_cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    t_cfg      w_cfg;
    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;
    logic      w_step;          // input register hands its byte to the parser
    logic      w_res_valid;
    t_out_item w_result;

    ipv4f_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    // Byte advances when the output register is empty or drains this cycle.
    assign w_step     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_item <= i_in_item;
        end
    end

    ipv4f_parser u_parser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (w_cfg),
        .i_step         (w_step),
        .i_item         (r_in_item),
        .o_result_valid (w_res_valid),
        .o_result       (w_result)
    );

    // Output register: loads a verdict, or empties once the transfer completes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step && w_res_valid) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step && w_res_valid) begin
            r_out_item <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // No verdict appears without a parser step.
    `IPV4F_ASSERT_NEXT(a_no_spurious_out, i_clk, i_rst_n, !w_step && !r_out_valid, !r_out_valid)
    // A held byte stays in the input register unchanged.
    `IPV4F_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, r_in_valid && !w_step,
                       r_in_valid && $stable(r_in_item))
    // Malformed headers report protocol zero and a short length.
    `IPV4F_ASSERT_SAME(a_malformed_fields, i_clk, i_rst_n,
                       r_out_valid && r_out_item.verdict == VERDICT_MALFORMED,
                       r_out_item.protocol_number == 8'd0 &&
                       r_out_item.header_length < HDR_LEN_MIN)
    // Every other verdict comes from a full-length header.
    `IPV4F_ASSERT_SAME(a_full_length, i_clk, i_rst_n,
                       r_out_valid && r_out_item.verdict != VERDICT_MALFORMED,
                       r_out_item.header_length >= HDR_LEN_MIN)

endmodule

>>> sim/ipv4f_verdict_monitor.sv
`timescale 1ns / 1ps

// Watches the byte and verdict channels plus register writes, tracks the
// header parse on its own, and compares every verdict transfer in order.
module ipv4f_verdict_monitor import ipv4f_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  logic                   i_in_ready,
    input  t_in_item               i_in_item,
    input  logic                   i_out_valid,
    input  logic                   i_out_ready,
    input  t_out_item              i_out_item,
    input  logic                   i_cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    output int                     o_fail_count,
    output int                     o_pending,
    output int                     o_checked
);

    // Byte offsets inside the header
    localparam logic [5:0] POS_FRAG_HI = 6'd6;
    localparam logic [5:0] POS_FRAG_LO = 6'd7;
    localparam logic [5:0] POS_PROTO   = 6'd9;
    localparam logic [5:0] POS_DST     = 6'd16;

    t_cfg        filter_cfg;
    logic [5:0]  byte_pos;
    logic [3:0]  ihl_words;
    logic [15:0] csum_acc;
    logic [7:0]  high_byte;
    logic [31:0] dst_addr;
    logic [15:0] frag_word;
    logic [7:0]  proto;
    logic        in_header;

    t_out_item   expected_verdicts[$];
    int          mismatches = 0;
    int          verdicts_checked = 0;

    assign o_fail_count = mismatches;
    assign o_checked    = verdicts_checked;

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("[%0t] verdict mismatch: %s", $time, msg);
    endtask

    always @(posedge i_clk) begin : header_tracker
        t_out_item   want;
        t_out_item   fresh;
        logic        has_fresh;
        logic [16:0] wide_sum;
        logic [5:0]  hdr_len;
        logic [7:0]  b;
        if (!i_rst_n) begin
            filter_cfg = '0;
            byte_pos   = '0;
            ihl_words  = '0;
            csum_acc   = '0;
            high_byte  = '0;
            dst_addr   = '0;
            frag_word  = '0;
            proto      = '0;
            in_header  = 1'b0;
            expected_verdicts.delete();
        end else begin
            // Outputs first: a verdict leaving now always belongs to an older byte.
            if (i_out_valid && i_out_ready) begin
                if (expected_verdicts.size() == 0) begin
                    report_mismatch($sformatf("unexpected verdict %0d proto %0d len %0d",
                        i_out_item.verdict, i_out_item.protocol_number,
                        i_out_item.header_length));
                end else begin
                    want = expected_verdicts.pop_front();
                    verdicts_checked++;
                    if (i_out_item.verdict != want.verdict)
                        report_mismatch($sformatf("verdict got %0d want %0d",
                            i_out_item.verdict, want.verdict));
                    if (i_out_item.protocol_number != want.protocol_number)
                        report_mismatch($sformatf("protocol got %0d want %0d",
                            i_out_item.protocol_number, want.protocol_number));
                    if (i_out_item.header_length != want.header_length)
                        report_mismatch($sformatf("length got %0d want %0d",
                            i_out_item.header_length, want.header_length));
                end
            end

            if (i_in_valid && i_in_ready) begin
                b         = i_in_item.header_byte;
                has_fresh = 1'b0;
                fresh     = '0;
                if (i_in_item.first_byte) begin
                    // new header; anything in progress is dropped silently
                    byte_pos  = '0;
                    csum_acc  = '0;
                    high_byte = '0;
                    dst_addr  = '0;
                    frag_word = '0;
                    proto     = '0;
                    ihl_words = b[3:0];
                    if (ihl_words < IHL_MASK_MIN) begin
                        in_header           = 1'b0;
                        has_fresh           = 1'b1;
                        fresh.verdict       = VERDICT_MALFORMED;
                        fresh.header_length = {ihl_words, 2'b00};
                    end else begin
                        in_header = 1'b1;
                    end
                end
                if (in_header) begin
                    if (!byte_pos[0]) begin
                        high_byte = b;
                    end else begin
                        wide_sum = {1'b0, csum_acc} + {1'b0, high_byte, b};
                        csum_acc = wide_sum[15:0] + {15'd0, wide_sum[16]};
                    end
                    case (byte_pos)
                        POS_FRAG_HI: frag_word[15:8] = b;
                        POS_FRAG_LO: frag_word[7:0]  = b;
                        POS_PROTO:   proto           = b;
                        POS_DST, POS_DST + 6'd1, POS_DST + 6'd2, POS_DST + 6'd3:
                            dst_addr = {dst_addr[23:0], b};
                        default: ;
                    endcase
                    hdr_len = {ihl_words, 2'b00};
                    if (byte_pos + 6'd1 >= hdr_len) begin
                        in_header = 1'b0;
                        byte_pos  = '0;
                        has_fresh = 1'b1;
                        if (csum_acc != CSUM_GOOD)
                            fresh.verdict = VERDICT_BAD_CSUM;
                        else if (dst_addr != filter_cfg.local_address)
                            fresh.verdict = VERDICT_WRONG_DST;
                        else if ((frag_word & (FLAG_MF | FRAG_OFS_MASK)) != '0)
                            fresh.verdict = VERDICT_FRAGMENT;
                        else if (proto == PROTO_ICMP)
                            fresh.verdict = VERDICT_ICMP;
                        else if (proto == PROTO_UDP && filter_cfg.udp_enabled)
                            fresh.verdict = VERDICT_UDP;
                        else if (proto == PROTO_TCP && filter_cfg.tcp_enabled)
                            fresh.verdict = VERDICT_TCP;
                        else
                            fresh.verdict = VERDICT_UNKNOWN;
                        fresh.protocol_number = proto;
                        fresh.header_length   = hdr_len;
                    end else begin
                        byte_pos = byte_pos + 6'd1;
                    end
                end
                if (has_fresh)
                    expected_verdicts.push_back(fresh);
            end

            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_LOCAL_ADDRESS: filter_cfg.local_address = i_cfg_data;
                    CFG_UDP_ENABLED:   filter_cfg.udp_enabled   = i_cfg_data[0];
                    CFG_TCP_ENABLED:   filter_cfg.tcp_enabled   = i_cfg_data[0];
                    default: ;
                endcase
            end
        end
        o_pending <= expected_verdicts.size();
    end

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the IPv4 receive header filter. Checking lives in
// the verdict monitor; this module feeds bytes, writes registers, drives the
// verdict-side backpressure and runs a hang watchdog.
module tb_top;
    import ipv4f_pkg::*;

    localparam int RESET_CYCLES   = 12;
    localparam int ITEM_TARGET    = 1050;   // header bytes, directed part included
    localparam int PHASES         = 5;      // register settings in the random part
    localparam int DRAIN_CYCLES   = 6;      // settle margin after the last verdict
    localparam int HOLD_CYCLES    = 300;    // long verdict-side hold-off
    localparam int WATCHDOG_LIMIT = 3000;   // cycles with no transfer at all
    localparam int FULL_HEADER    = 64;     // cut point past any header length

    // Index 3 maps to no register; writes there must change nothing.
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_INDEX = 2'd3;

    localparam logic [31:0] BENCH_ADDR     = 32'hC0A8_0A01;
    localparam logic [3:0]  IPV4_VERSION   = 4'd4;
    localparam logic [3:0]  IHL_MAX        = 4'd15;
    localparam logic [7:0]  PROTO_NONE     = 8'd0;
    localparam logic [7:0]  PROTO_RESERVED = 8'hFF;
    localparam logic [15:0] FLAG_DF        = 16'h4000;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    t_in_item               in_item;
    logic                   out_valid;
    logic                   out_ready;
    t_out_item              out_item;
    logic                   cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    int                     fail_count;
    int                     pending;
    int                     checked;

    // stimulus bookkeeping
    int                     bytes_sent    = 0;
    int                     headers_done  = 0;
    int                     settings_used = 0;
    int                     gap_pct       = 20;   // chance of an input gap per byte
    logic                   idle_on       = 1'b1; // cleared for the closing phase
    logic                   hold_request  = 1'b0; // asks the verdict side for a long hold
    logic [31:0]            cur_addr      = '0;   // address the filter now answers to

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    ipv4_rx_header_filter DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    ipv4f_verdict_monitor u_verdict_monitor (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_item   (out_item),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    // One byte transfer. An optional gap drops valid first; otherwise valid
    // stays high straight into the next byte.
    task automatic send_byte(input logic [7:0] value, input logic first);
        if (idle_on && gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= '{header_byte: value, first_byte: first};
        do @(posedge clk); while (!in_ready);
        bytes_sent++;
    endtask

    // Unmarked bytes: payload after a header, or noise while the parser is idle.
    task automatic send_junk(input int count);
        for (int n = 0; n < count; n++)
            send_byte(8'($urandom), 1'b0);
    endtask

    // Builds a header with a valid checksum, optionally corrupts one bit past
    // byte 0, and sends it up to the cut point. An IHL below five sends only
    // byte 0, since the filter rejects it right there.
    task automatic send_header(input logic [3:0] ver, input logic [3:0] ihl,
                               input logic [31:0] dst, input logic [7:0] proto,
                               input logic [15:0] frag, input bit break_csum,
                               input int cut);
        logic [7:0]  hdr [0:59];
        logic [16:0] acc;
        logic [15:0] sum16;
        int          len;
        int          pos;
        len = int'(ihl) * 4;
        if (ihl < IHL_MASK_MIN) begin
            send_byte({ver, ihl}, 1'b1);
            headers_done++;
        end else begin
            for (pos = 0; pos < len; pos++)
                hdr[pos] = 8'($urandom);
            hdr[0]  = {ver, ihl};
            hdr[6]  = frag[15:8];
            hdr[7]  = frag[7:0];
            hdr[9]  = proto;
            hdr[10] = '0;
            hdr[11] = '0;
            hdr[16] = dst[31:24];
            hdr[17] = dst[23:16];
            hdr[18] = dst[15:8];
            hdr[19] = dst[7:0];
            sum16 = '0;
            for (pos = 0; pos < len; pos += 2) begin
                acc   = {1'b0, sum16} + {1'b0, hdr[pos], hdr[pos + 1]};
                sum16 = acc[15:0] + {15'd0, acc[16]};
            end
            {hdr[10], hdr[11]} = ~sum16;
            if (break_csum) begin
                pos      = $urandom_range(1, len - 1);
                hdr[pos] = hdr[pos] ^ (8'd1 << $urandom_range(0, 7));
            end
            for (pos = 0; pos < cut && pos < len; pos++)
                send_byte(hdr[pos], pos == 0);
            if (cut >= len)
                headers_done++;
        end
    endtask

    // Register writes only happen with the filter idle: stop offering bytes,
    // wait for every verdict owed, then let the pipeline settle.
    task automatic quiesce();
        in_valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Back-to-back writes of all three registers plus the unused index;
    // enable drops once at the end.
    task automatic program_filter(input logic [31:0] addr, input logic [31:0] udp_word,
                                  input logic [31:0] tcp_word);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_LOCAL_ADDRESS;
        cfg_data  <= addr;
        @(posedge clk);
        cfg_index <= CFG_UDP_ENABLED;
        cfg_data  <= udp_word;
        @(posedge clk);
        cfg_index <= CFG_TCP_ENABLED;
        cfg_data  <= tcp_word;
        @(posedge clk);
        cfg_index <= CFG_SPARE_INDEX;
        cfg_data  <= $urandom;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        cur_addr = addr;
        settings_used++;
    endtask

    // Verdict-side backpressure: random ready runs and stall bursts, plus one
    // long hold-off on request so the filter backs up and stalls its input.
    initial begin : verdict_sink
        logic hold_served;
        hold_served = 1'b0;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            if (hold_request && !hold_served) begin
                hold_served = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
            end else begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge clk);
            end
        end
    end

    // Watchdog: too long without any transfer means the filter hung.
    int stall_cycles = 0;
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer in %0d cycles, %0d verdicts owed",
                     WATCHDOG_LIMIT, pending);
            $display("FAIL");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin : stimulus
        int          phase;
        int          quota;
        int          base;
        int          pick;
        int          cut;
        logic [3:0]  ihl;
        logic [3:0]  ver;
        logic [7:0]  proto;
        logic [31:0] dst;
        logic [15:0] frag;
        bit          break_csum;

        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_item   <= '0;
        cfg_wr_en <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- Directed: registers at reset values (address 0, UDP/TCP off) ---
        send_junk(3);                                   // idle noise, ignored
        send_header(4'd0, 4'd0, '0, PROTO_ICMP, '0, 1'b0, FULL_HEADER);      // all-zero byte 0
        send_header(IPV4_VERSION, 4'd4, '0, PROTO_ICMP, '0, 1'b0, FULL_HEADER);
        send_header(IPV4_VERSION, IHL_MASK_MIN, '0, PROTO_ICMP, '0, 1'b0, FULL_HEADER);
        send_header(IPV4_VERSION, IHL_MASK_MIN, '0, PROTO_UDP, '0, 1'b0, FULL_HEADER);
        quiesce();

        // --- Directed: both protocols on ---
        program_filter(BENCH_ADDR, 32'd1, 32'd1);
        send_header(IPV4_VERSION, IHL_MASK_MIN, BENCH_ADDR, PROTO_UDP, '0, 1'b0, FULL_HEADER);
        send_header(IPV4_VERSION, IHL_MASK_MIN, BENCH_ADDR, PROTO_TCP, '0, 1'b0, FULL_HEADER);
        send_header(IPV4_VERSION, IHL_MASK_MIN, BENCH_ADDR, PROTO_NONE, '0, 1'b0, FULL_HEADER);
        send_header(IPV4_VERSION, IHL_MASK_MIN, BENCH_ADDR, PROTO_RESERVED, '0, 1'b0,
                    FULL_HEADER);
        // all-ones byte 0: longest header, options included
        send_header(4'hF, IHL_MAX, BENCH_ADDR, PROTO_ICMP, '0, 1'b0, FULL_HEADER);
        // checksum beats destination, destination beats fragment
        send_header(IPV4_VERSION, IHL_MASK_MIN, ~BENCH_ADDR, PROTO_ICMP, FLAG_MF, 1'b1,
                    FULL_HEADER);
        send_header(IPV4_VERSION, IHL_MASK_MIN, ~BENCH_ADDR, PROTO_ICMP, FLAG_MF, 1'b0,
                    FULL_HEADER);
        send_header(IPV4_VERSION, IHL_MASK_MIN, BENCH_ADDR, PROTO_UDP, FLAG_MF, 1'b0,
                    FULL_HEADER);
        send_header(IPV4_VERSION, IHL_MASK_MIN, BENCH_ADDR, PROTO_TCP, FRAG_OFS_MASK, 1'b0,
                    FULL_HEADER);
        // don't-fragment alone is not a fragment
        send_header(IPV4_VERSION, IHL_MASK_MIN, BENCH_ADDR, PROTO_TCP, FLAG_DF, 1'b0,
                    FULL_HEADER);
        // header cut short, restarted by a new first byte
        send_header(IPV4_VERSION, IHL_MASK_MIN, BENCH_ADDR, PROTO_UDP, '0, 1'b0, 7);
        send_header(IPV4_VERSION, 4'd6, BENCH_ADDR, PROTO_ICMP, '0, 1'b0, FULL_HEADER);
        send_junk(5);                                   // trailing payload, ignored
        quiesce();

        // --- Directed: protocols off; upper data bits must not matter ---
        program_filter(BENCH_ADDR, 32'hFFFF_FFFE, 32'd0);
        send_header(IPV4_VERSION, IHL_MASK_MIN, BENCH_ADDR, PROTO_UDP, '0, 1'b0, FULL_HEADER);
        send_header(IPV4_VERSION, IHL_MASK_MIN, BENCH_ADDR, PROTO_TCP, '0, 1'b0, FULL_HEADER);

        // --- Random: one register setting per phase, remaining bytes split evenly ---
        base = bytes_sent;
        for (phase = 0; phase < PHASES; phase++) begin
            quiesce();
            case (phase)
                0: program_filter($urandom, 32'd1, 32'd1);
                1: program_filter(32'd0, {31'($urandom), 1'b0}, {31'($urandom), 1'b1});
                2: program_filter(32'hFFFF_FFFF, 32'd1, 32'd0);
                3: program_filter($urandom, 32'd0, 32'd0);
                default: program_filter($urandom, {31'($urandom), 1'b1}, 32'd1);
            endcase
            if (phase == 2)
                hold_request = 1'b1;            // verdict side backs off; input should stall
            if (phase == PHASES - 1)
                idle_on = 1'b0;                 // closing phase runs at full rate
            quota = base + (ITEM_TARGET - base) * (phase + 1) / PHASES;
            while (bytes_sent < quota) begin
                // input gap density varies header to header, none at all sometimes
                case ($urandom_range(0, 2))
                    0: gap_pct = 0;
                    1: gap_pct = 8;
                    default: gap_pct = 30;
                endcase
                // mostly plain 20-byte headers, some with options, a few too short
                pick = $urandom_range(0, 99);
                if (pick < 70)
                    ihl = IHL_MASK_MIN;
                else if (pick < 93)
                    ihl = 4'($urandom_range(6, 15));
                else
                    ihl = 4'($urandom_range(0, 4));
                case ($urandom_range(0, 4))
                    0: proto = PROTO_ICMP;
                    1: proto = PROTO_UDP;
                    2: proto = PROTO_TCP;
                    default: proto = 8'($urandom);
                endcase
                dst = ($urandom_range(0, 3) != 0) ? cur_addr : $urandom;
                pick = $urandom_range(0, 9);
                if (pick == 0)
                    frag = 16'($urandom);
                else if (pick == 1)
                    frag = FLAG_DF;
                else
                    frag = '0;
                ver = ($urandom_range(0, 7) == 0) ? 4'($urandom) : IPV4_VERSION;
                break_csum = ($urandom_range(0, 9) == 0);
                if (ihl >= IHL_MASK_MIN && $urandom_range(0, 14) == 0)
                    cut = $urandom_range(1, int'(ihl) * 4 - 1);
                else
                    cut = FULL_HEADER;
                send_header(ver, ihl, dst, proto, frag, break_csum, cut);
                if ($urandom_range(0, 4) == 0)
                    send_junk($urandom_range(1, 4));
            end
        end

        // drain everything owed, then let the pipeline settle
        quiesce();

        $display("Covered %0d header bytes in %0d full headers, %0d verdicts checked,",
                 bytes_sent, headers_done, checked);
        $display("%0d register settings, input gaps, output stalls, a long hold-off; %0d bad.",
                 settings_used, fail_count);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+sv
sv/ipv4f_pkg.sv
sv/ipv4f_cfg_regs.sv
sv/ipv4f_parser.sv
sv/ipv4_rx_header_filter.sv
sim/ipv4f_verdict_monitor.sv
sim/tb_top.sv
